// File: rtl/tcc_pkg.sv
// Shared types, constants and helpers for the text console cursor and scroll core.
`default_nettype none
package tcc_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int TAB_STOP   = 8;
	localparam int CELL_COUNT = COLUMNS * ROWS;

	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int CELL_W = 11;
	localparam int DATA_W = 16;

	localparam logic [7:0] CODE_BS    = 8'h08;
	localparam logic [7:0] CODE_TAB   = 8'h09;
	localparam logic [7:0] CODE_LF    = 8'h0A;
	localparam logic [7:0] CODE_CR    = 8'h0D;
	localparam logic [7:0] CODE_SPACE = 8'h20;
	localparam logic [7:0] RESET_ATTR = 8'h0F;

	localparam logic [1:0] FN_PUT   = 2'd0;
	localparam logic [1:0] FN_CLEAR = 2'd1;
	localparam logic [1:0] FN_READ  = 2'd2;

	localparam logic [1:0] WS_CHAR  = 2'd0;
	localparam logic [1:0] WS_BLANK = 2'd1;
	localparam logic [1:0] WS_RESET = 2'd2;
	localparam logic [1:0] WS_MOVE  = 2'd3;

	localparam logic RS_ADDR   = 1'b0;
	localparam logic RS_SCROLL = 1'b1;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  char_code;
		logic [10:0] cell_address;
	} in_item_t;

	typedef struct packed {
		logic [6:0]  cursor_column;
		logic [4:0]  cursor_line;
		logic [10:0] cursor_index;
		logic [15:0] cell_value;
	} out_item_t;

	typedef struct packed {
		logic       load_op;
		logic       exec_put;
		logic       home;
		logic       ptr_inc;
		logic       mem_we;
		logic [1:0] wsel;
		logic       rsel;
		logic       cap_val;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       printable;
		logic       scroll_need;
		logic       ptr_last;
		logic       ptr_scr_last;
		logic       out_busy;
	} stat_t;

	function automatic logic [CELL_W-1:0] cell_index(
		input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col
	);
		logic [CELL_W-1:0] base;
		base = CELL_W'(row) * CELL_W'(COLUMNS);
		return base + CELL_W'(col);
	endfunction

endpackage
`default_nettype wire

// File: rtl/tcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tcc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/tcc_ctrl.sv
// Controller state machine: sequences put, clear, scroll, read and the reset clearing pass.
`default_nettype none
module tcc_ctrl (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           in_valid,
	output logic          in_stall,
	input  wire tcc_pkg::stat_t stat,
	output tcc_pkg::cmd_t  cmd
);
	import tcc_pkg::*;

	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_EXEC   = 3'd2;
	localparam logic [2:0] ST_FILL   = 3'd3;
	localparam logic [2:0] ST_SCR_RD = 3'd4;
	localparam logic [2:0] ST_SCR_WR = 3'd5;
	localparam logic [2:0] ST_RDW    = 3'd6;
	localparam logic [2:0] ST_FIN    = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_stall = 1'b1;
		unique case (state_q)
			ST_INIT: begin
				cmd.mem_we  = 1'b1;
				cmd.wsel    = WS_RESET;
				cmd.ptr_inc = 1'b1;
				if (stat.ptr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_op = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (stat.func)
					FN_PUT: begin
						cmd.exec_put = 1'b1;
						cmd.mem_we   = stat.printable;
						cmd.wsel     = WS_CHAR;
						state_d      = stat.scroll_need ? ST_SCR_RD : ST_FIN;
					end
					FN_CLEAR: begin
						cmd.home = 1'b1;
						state_d  = ST_FILL;
					end
					FN_READ: begin
						cmd.rsel = RS_ADDR;
						state_d  = ST_RDW;
					end
					default: begin
						state_d = ST_FIN;
					end
				endcase
			end
			ST_FILL: begin
				cmd.mem_we  = 1'b1;
				cmd.wsel    = WS_BLANK;
				cmd.ptr_inc = 1'b1;
				if (stat.ptr_last) begin
					state_d = ST_FIN;
				end
			end
			ST_SCR_RD: begin
				cmd.rsel = RS_SCROLL;
				state_d  = ST_SCR_WR;
			end
			ST_SCR_WR: begin
				cmd.mem_we  = 1'b1;
				cmd.wsel    = WS_MOVE;
				cmd.ptr_inc = 1'b1;
				state_d     = stat.ptr_scr_last ? ST_FILL : ST_SCR_RD;
			end
			ST_RDW: begin
				cmd.cap_val = 1'b1;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

// File: rtl/tcc_dpath.sv
// Datapath: cursor, attribute, sweep pointer, screen store and result register.
`default_nettype none
module tcc_dpath (
	input  wire              clk,
	input  wire              arst_n,
	input  wire tcc_pkg::in_item_t in_data,
	input  wire              cfg_we,
	input  wire [7:0]        cfg_wdata,
	output logic             out_valid,
	input  wire              out_stall,
	output tcc_pkg::out_item_t out_data,
	input  wire tcc_pkg::cmd_t cmd,
	output tcc_pkg::stat_t    stat
);
	import tcc_pkg::*;

	logic [1:0]        func_q;
	logic [7:0]        code_q;
	logic [CELL_W-1:0] addr_q;
	logic [7:0]        attr_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [CELL_W-1:0] ptr_q;
	logic [DATA_W-1:0] val_q;

	logic [COL_W:0]    col_w;
	logic [COL_W:0]    col_n;
	logic [ROW_W:0]    row_n;
	logic [COL_W-1:0]  col_fin;
	logic [ROW_W-1:0]  row_fin;
	logic              printable;

	logic              ram_we;
	logic [CELL_W-1:0] ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [CELL_W-1:0] ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	assign printable = (code_q >= CODE_SPACE);
	assign col_w     = {1'b0, col_q};

	always_comb begin
		col_n = col_w;
		row_n = {1'b0, row_q};
		case (code_q)
			CODE_BS: begin
				if (col_q != '0) begin
					col_n = col_w - 1'b1;
				end
			end
			CODE_TAB: begin
				col_n = (COL_W+1)'((col_w / TAB_STOP + 1) * TAB_STOP);
			end
			CODE_CR: begin
				col_n = '0;
			end
			CODE_LF: begin
				col_n = '0;
				row_n = row_n + 1'b1;
			end
			default: begin
				if (printable) begin
					col_n = col_w + 1'b1;
				end
			end
		endcase
		if (col_n >= (COL_W+1)'(COLUMNS)) begin
			col_n = '0;
			row_n = row_n + 1'b1;
		end
		col_fin = col_n[COL_W-1:0];
		if (row_n >= (ROW_W+1)'(ROWS)) begin
			row_fin = ROW_W'(ROWS - 1);
		end else begin
			row_fin = row_n[ROW_W-1:0];
		end
	end

	always_comb begin
		stat.func         = func_q;
		stat.printable    = printable;
		stat.scroll_need  = (row_n >= (ROW_W+1)'(ROWS));
		stat.ptr_last     = (ptr_q == CELL_W'(CELL_COUNT - 1));
		stat.ptr_scr_last = (ptr_q == CELL_W'((ROWS - 1) * COLUMNS - 1));
		stat.out_busy     = out_valid && out_stall;
	end

	always_comb begin
		ram_we    = cmd.mem_we;
		ram_waddr = ptr_q;
		case (cmd.wsel)
			WS_CHAR: begin
				ram_waddr = cell_index(row_q, col_q);
				ram_wdata = {attr_q, code_q};
			end
			WS_BLANK: ram_wdata = {attr_q, CODE_SPACE};
			WS_RESET: ram_wdata = {RESET_ATTR, CODE_SPACE};
			default:  ram_wdata = ram_rdata;
		endcase
		if (cmd.rsel == RS_SCROLL) begin
			ram_raddr = ptr_q + CELL_W'(COLUMNS);
		end else begin
			ram_raddr = addr_q;
		end
	end

	tcc_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CELL_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q    <= RESET_ATTR;
			col_q     <= '0;
			row_q     <= '0;
			ptr_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				attr_q <= cfg_wdata;
			end
			if (cmd.exec_put) begin
				col_q <= col_fin;
				row_q <= row_fin;
			end else if (cmd.home) begin
				col_q <= '0;
				row_q <= '0;
			end
			if (cmd.load_op) begin
				ptr_q <= '0;
			end else if (cmd.exec_put) begin
				ptr_q <= '0;
			end else if (cmd.ptr_inc) begin
				ptr_q <= stat.ptr_last ? '0 : ptr_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_op) begin
			func_q <= in_data.func;
			code_q <= in_data.char_code;
			addr_q <= in_data.cell_address;
			val_q  <= '0;
		end else if (cmd.cap_val) begin
			val_q <= (addr_q < CELL_W'(CELL_COUNT)) ? ram_rdata : '0;
		end
		if (cmd.load_out) begin
			out_data.cursor_column <= col_q;
			out_data.cursor_line   <= row_q;
			out_data.cursor_index  <= cell_index(row_q, col_q);
			out_data.cell_value    <= val_q;
		end
	end
endmodule
`default_nettype wire

// File: rtl/text_console_cursor_scroll_core.sv
// Top level of the text console: 80x25 cell store, cursor, scroll and clear.
//
// Input channel in_valid/in_stall/in_data carries one operation per transfer:
// put character, clear screen or read cell. Output channel out_valid/out_stall/
// out_data returns one result per operation: cursor column, row, linear index
// and, for a read, the stored cell (zero otherwise). cfg_we/cfg_wdata write the
// attribute byte used for new cells; write it only while the block is idle.
// Items are handled one at a time by a controller over a single-port-write,
// registered-read cell RAM:
//   clear screen: one cell written per cycle;
//   put character that scrolls: read then write of each moved cell, then
//   the bottom row filled.
// After reset a clearing pass writes every cell to a space with attribute
// 0x0F, with in_stall high; config writes are taken meanwhile.
// A result waits in the output register while out_stall is high; the next
// operation is then accepted and processed, and its result waits behind it.
`default_nettype none
module text_console_cursor_scroll_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire tcc_pkg::in_item_t in_data,
	output logic                out_valid,
	input  wire                 out_stall,
	output tcc_pkg::out_item_t  out_data,
	input  wire                 cfg_we,
	input  wire [7:0]           cfg_wdata
);
	import tcc_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	tcc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stat    (stat),
		.cmd     (cmd)
	);

	tcc_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cmd      (cmd),
		.stat     (stat)
	);
endmodule
`default_nettype wire
